// File: rtl/mtac_pkg.sv
`timescale 1ns / 1ps
// Package for the memory tag access checker: beat structs, codes and the
// permission table. No dependencies.
package mtac_pkg;

  localparam int IndexBitsDef    = 10;
  localparam int GranuleShiftDef = 3;
  localparam int TagBitsDef      = 2;
  localparam int NarrowBits      = 32;

  localparam logic [1:0] REQ_STORE = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_SUPER   = 2'd1;
  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  localparam logic [7:0] TAG_N  = 8'd0;
  localparam logic [7:0] TAG_C  = 8'd1;
  localparam logic [7:0] TAG_UT = 8'd2;
  localparam logic [7:0] TAG_MAX_CHECKED = 8'd3;

  // permission bits: [0] read, [1] write, [2] execute
  localparam logic [2:0] PERM_RWX = 3'b111;
  localparam logic [2:0] PERM_X   = 3'b100;
  localparam logic [2:0] PERM_RX  = 3'b101;
  localparam logic [2:0] PERM_RW  = 3'b011;
  localparam logic [2:0] PERM_NONE = 3'b000;

  // row: {secure, supervisor}, column: target tag
  localparam logic [2:0] PERM_TABLE [4][4] = '{
    '{PERM_RWX, PERM_X,   PERM_NONE, PERM_NONE},
    '{PERM_RWX, PERM_X,   PERM_NONE, PERM_NONE},
    '{PERM_RWX, PERM_RX,  PERM_RWX,  PERM_RX},
    '{PERM_RWX, PERM_RWX, PERM_RW,   PERM_RWX}
  };

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] addr;
    logic [7:0]  tag_value;
    logic [1:0]  access_kind;
    logic [1:0]  priv_level;
    logic        translation_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_tag;
    logic       allowed;
    logic       illegal_trap;
    logic       secure_now;
  } out_item_t;

endpackage

// File: rtl/memory_tag_access_checker.sv
`timescale 1ns / 1ps
// Memory tag access checker top level: tag memory, domain bit, one check stage.
// Depends on mtac_pkg.
//
// Usage:
//   Input: drive in_item and raise start; the beat is taken at an edge where
//   start is high and busy is low. One result beat per input beat.
//   Output: out_valid strobes for one cycle with out_item; the receiver must
//   take it then, it cannot stall the block.
//   Config: cfg_data holds narrow_addresses; written when cfg_valid and
//   cfg_ready are high. cfg_ready is always high. Write only while idle.
//   Pipeline: at the accepting edge the tag memory is read and the beat is
//   registered in the check stage; the decision and the tag write-back are
//   then registered, the result into out_item and out_valid.
//   A new beat may be taken every cycle while busy is low; a store followed by a
//   request to the same granule is served by forwarding the written tag.
//   Reset: rst_n low clears the domain bit and narrow_addresses, then busy
//   stays high while all 2^INDEX_BITS entries (1024 by default) of the tag
//   memory are swept to the normal tag, one entry per cycle.
module memory_tag_access_checker #(
  parameter int INDEX_BITS    = mtac_pkg::IndexBitsDef,
  parameter int GRANULE_SHIFT = mtac_pkg::GranuleShiftDef,
  parameter int TAG_BITS      = mtac_pkg::TagBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mtac_pkg::in_item_t  in_item,
  output logic                out_valid,
  output mtac_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import mtac_pkg::*;

  localparam int Depth = 1 << INDEX_BITS;

  logic [TAG_BITS-1:0]   mem [Depth];
  logic [TAG_BITS-1:0]   mem_rd_r;

  logic                  narrow_r;
  logic                  secure_r, secure_nxt;
  logic                  clr_active_r;
  logic [INDEX_BITS-1:0] clr_cnt_r;

  logic                  s1_valid_r;
  in_item_t              s1_item_r;
  logic [INDEX_BITS-1:0] s1_idx_r;
  logic                  fwd_hit_r;
  logic [TAG_BITS-1:0]   fwd_tag_r;

  logic                  out_valid_r;
  out_item_t             out_item_r, out_item_nxt;

  logic                  accept;
  logic [63:0]           addr_eff;
  logic [63:0]           addr_sh;
  logic [INDEX_BITS-1:0] acc_idx;

  logic [TAG_BITS-1:0]   old_tag;
  logic [7:0]            old_ext;
  logic                  trap;
  logic                  st_wr;
  logic [2:0]            perm;
  logic                  perm_hit;
  logic                  check_ok;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_wa;
  logic [TAG_BITS-1:0]   mem_wd;

  assign busy      = clr_active_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !clr_active_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    addr_eff = narrow_r ? {{(64 - NarrowBits){1'b0}}, in_item.addr[NarrowBits-1:0]}
                        : in_item.addr;
    addr_sh  = addr_eff >> GRANULE_SHIFT;
    acc_idx  = addr_sh[INDEX_BITS-1:0];
  end

  always_comb begin
    old_tag  = fwd_hit_r ? fwd_tag_r : mem_rd_r;
    old_ext  = 8'(old_tag);
    perm     = PERM_TABLE[{secure_r, s1_item_r.priv_level == PRIV_SUPER}][old_ext[1:0]];
    perm_hit = (s1_item_r.access_kind == KIND_LOAD  && perm[0]) ||
               (s1_item_r.access_kind == KIND_STORE && perm[1]) ||
               (s1_item_r.access_kind == KIND_FETCH && perm[2]);
    check_ok = !s1_item_r.translation_on || s1_item_r.priv_level == PRIV_MACHINE ||
               (old_ext <= TAG_MAX_CHECKED && perm_hit);

    trap = 1'b0;
    if (s1_item_r.translation_on) begin
      if (!secure_r && s1_item_r.priv_level != PRIV_MACHINE &&
          (old_ext != TAG_N || s1_item_r.tag_value != TAG_N)) begin
        trap = 1'b1;
      end
      if (s1_item_r.priv_level == PRIV_USER && old_ext != TAG_N && old_ext != TAG_UT) begin
        trap = 1'b1;
      end
    end

    st_wr        = 1'b0;
    secure_nxt   = secure_r;
    out_item_nxt = '0;
    unique case (s1_item_r.req_type)
      REQ_STORE: begin
        st_wr                     = s1_valid_r && !trap;
        out_item_nxt.allowed      = !trap;
        out_item_nxt.illegal_trap = trap;
      end
      REQ_LOAD: begin
        out_item_nxt.read_tag = old_ext;
      end
      REQ_CHECK: begin
        out_item_nxt.allowed = check_ok;
        if (s1_valid_r && check_ok && s1_item_r.translation_on &&
            s1_item_r.priv_level != PRIV_MACHINE &&
            s1_item_r.access_kind == KIND_FETCH) begin
          if (!secure_r && old_ext == TAG_C) begin
            secure_nxt = 1'b1;
          end else if (secure_r && old_ext == TAG_N) begin
            secure_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    out_item_nxt.secure_now = secure_nxt;

    mem_we = clr_active_r || st_wr;
    mem_wa = clr_active_r ? clr_cnt_r : s1_idx_r;
    mem_wd = clr_active_r ? '0 : s1_item_r.tag_value[TAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[acc_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_r     <= 1'b0;
      secure_r     <= 1'b0;
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      fwd_hit_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        narrow_r <= cfg_data;
      end
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          clr_active_r <= 1'b0;
        end
      end
      secure_r    <= secure_nxt;
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
      fwd_hit_r   <= st_wr && (s1_idx_r == acc_idx);
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= in_item;
    s1_idx_r   <= acc_idx;
    fwd_tag_r  <= s1_item_r.tag_value[TAG_BITS-1:0];
    out_item_r <= out_item_nxt;
  end

  a_no_item_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r)
    else $error("item in stage during memory clear");

  a_stage_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_valid_r)
    else $error("stage beat did not produce a result");

  a_domain_only_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && s1_item_r.req_type == REQ_CHECK &&
      s1_item_r.access_kind == KIND_FETCH) |=> $stable(secure_r))
    else $error("domain bit changed without a fetch check");

endmodule

// File: tb/sv/memory_tag_access_checker_monitor.sv
`timescale 1ns / 1ps
// Result checker for the memory tag access checker: predicts each result beat from
// accepted request beats and config writes, and compares field by field.
// Depends on mtac_pkg.
module memory_tag_access_checker_monitor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  mtac_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  mtac_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_data,
  output int                  mismatch_count,
  output int                  pending_results,
  output int                  trap_count,
  output int                  switch_count
);
  import mtac_pkg::*;

  logic [TagBitsDef-1:0] tag_mem [2**IndexBitsDef];
  logic                  secure_bit;
  logic                  narrow;
  out_item_t             expected_results[$];
  out_item_t             want;
  int                    err_cnt = 0;
  int                    traps = 0;
  int                    switches = 0;

  function automatic out_item_t predict_access(input in_item_t it);
    logic [63:0]            a;
    logic [IndexBitsDef-1:0] gi;
    logic [7:0]             old_tag;
    logic [1:0]             row;
    logic                   trap;
    out_item_t              r;
    r = '0;
    a = narrow ? {32'd0, it.addr[31:0]} : it.addr;
    gi = a[GranuleShiftDef +: IndexBitsDef];
    old_tag = 8'(tag_mem[gi]);
    case (it.req_type)
      REQ_STORE: begin
        trap = 1'b0;
        if (it.translation_on) begin
          if (!secure_bit && it.priv_level != PRIV_MACHINE &&
              (old_tag != TAG_N || it.tag_value != TAG_N))
            trap = 1'b1;
          if (it.priv_level == PRIV_USER && old_tag != TAG_N && old_tag != TAG_UT)
            trap = 1'b1;
        end
        r.illegal_trap = trap;
        if (trap) begin
          traps++;
        end else begin
          tag_mem[gi] = it.tag_value[TagBitsDef-1:0];
          r.allowed = 1'b1;
        end
      end
      REQ_LOAD: begin
        r.read_tag = old_tag;
      end
      REQ_CHECK: begin
        if (!it.translation_on || it.priv_level == PRIV_MACHINE) begin
          r.allowed = 1'b1;
        end else begin
          row = {secure_bit, it.priv_level == PRIV_SUPER};
          if (old_tag <= TAG_MAX_CHECKED && it.access_kind <= KIND_FETCH &&
              PERM_TABLE[row][old_tag[1:0]][it.access_kind]) begin
            r.allowed = 1'b1;
            if (it.access_kind == KIND_FETCH) begin
              if (!secure_bit && old_tag == TAG_C) begin
                secure_bit = 1'b1;
                switches++;
              end else if (secure_bit && old_tag == TAG_N) begin
                secure_bit = 1'b0;
                switches++;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.secure_now = secure_bit;
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      err_cnt++;
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tag_mem[i]) tag_mem[i] = '0;
      secure_bit = 1'b0;
      narrow = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected result beat: expected none, actual %h", $time, out_item);
        end else begin
          want = expected_results.pop_front();
          compare_field("read_tag", want.read_tag, out_item.read_tag);
          compare_field("allowed", want.allowed, out_item.allowed);
          compare_field("illegal_trap", want.illegal_trap, out_item.illegal_trap);
          compare_field("secure_now", want.secure_now, out_item.secure_now);
        end
      end
      if (start && !busy) expected_results.push_back(predict_access(in_item));
      if (cfg_valid && cfg_ready) narrow = cfg_data;
    end
    mismatch_count  <= err_cnt;
    pending_results <= expected_results.size();
    trap_count      <= traps;
    switch_count    <= switches;
  end

endmodule

// File: tb/sv/memory_tag_access_checker_tb.sv
`timescale 1ns / 1ps
// Testbench top for the memory tag access checker: clock, reset, directed and
// random request beats, address-width config phases, watchdog and verdict.
// Depends on mtac_pkg, memory_tag_access_checker and memory_tag_access_checker_monitor.
module memory_tag_access_checker_tb;
  import mtac_pkg::*;

  localparam logic [1:0] REQ_NOP   = 2'd3;
  localparam logic [1:0] KIND_NOP  = 2'd3;
  localparam logic [1:0] PRIV_RSVD = 2'd2;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_ITEMS     = 463;
  localparam logic [63:0] ADDR_X = 64'h0000_0000_0000_0040;
  localparam logic [63:0] ADDR_Y = 64'h0000_0000_0000_0080;
  localparam logic [63:0] ADDR_Z = 64'h0000_0000_0000_00C0;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  int mismatch_count;
  int pending_results;
  int trap_count;
  int switch_count;
  int n_store = 0;
  int n_load = 0;
  int n_check = 0;
  int n_nop = 0;
  int n_cfg = 0;
  int n_items = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  logic [IndexBitsDef-1:0] pool_gran [16];

  memory_tag_access_checker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  memory_tag_access_checker_monitor u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .trap_count      (trap_count),
    .switch_count    (switch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t mk(input logic [1:0] req, input logic [63:0] addr,
                                  input logic [7:0] tag, input logic [1:0] kind,
                                  input logic [1:0] priv, input logic xlat);
    in_item_t it;
    it.req_type       = req;
    it.addr           = addr;
    it.tag_value      = tag;
    it.access_kind    = kind;
    it.priv_level     = priv;
    it.translation_on = xlat;
    return it;
  endfunction

  function automatic logic [63:0] rand_addr(input bit from_pool);
    logic [63:0] a;
    a = {$urandom, $urandom};
    if (from_pool) a[GranuleShiftDef +: IndexBitsDef] = pool_gran[$urandom_range(0, 15)];
    return a;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    it.req_type = r < 35 ? REQ_STORE : r < 55 ? REQ_LOAD : r < 96 ? REQ_CHECK : REQ_NOP;
    it.addr = rand_addr($urandom_range(0, 4) != 0);
    r = $urandom_range(0, 9);
    it.tag_value = r < 4 ? TAG_N : r < 8 ? 8'($urandom_range(0, 3)) : 8'($urandom);
    it.access_kind = $urandom_range(0, 9) == 0 ? KIND_NOP : 2'($urandom_range(0, 2));
    it.priv_level = 2'($urandom_range(0, 3));
    it.translation_on = $urandom_range(0, 4) != 0;
    return it;
  endfunction

  // hold start high across back-to-back beats; drop it only for a gap
  task automatic push_item(input in_item_t it);
    int gap;
    int r;
    if (no_idle) begin
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      gap = r < 60 ? 0 : r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    case (it.req_type)
      REQ_STORE: n_store++;
      REQ_LOAD:  n_load++;
      REQ_CHECK: n_check++;
      default:   n_nop++;
    endcase
    if (it.req_type != REQ_NOP) n_items++;
  endtask

  task automatic write_narrow(input logic value);
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic [1:0] user_or_super();
    return $urandom_range(0, 1) ? PRIV_SUPER : PRIV_USER;
  endfunction

  task automatic run_sequence();
    int          r;
    logic [63:0] g;
    logic [63:0] h;
    no_idle = $urandom_range(0, 3) == 0;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      // enter the secure domain through a callable granule, work there, leave via a normal one
      g = rand_addr(1'b1);
      h = rand_addr(1'b1);
      push_item(mk(REQ_STORE, g, TAG_C, 2'($urandom_range(0, 3)), PRIV_MACHINE, 1'b1));
      repeat ($urandom_range(0, 3)) push_item(rand_item());
      push_item(mk(REQ_CHECK, {32'($urandom), g[31:0]}, 8'($urandom), KIND_FETCH,
                   user_or_super(), 1'b1));
      repeat ($urandom_range(1, 6)) push_item(rand_item());
      push_item(mk(REQ_STORE, h, TAG_N, 2'($urandom_range(0, 3)), PRIV_MACHINE, 1'b1));
      push_item(mk(REQ_CHECK, h, 8'($urandom), KIND_FETCH, user_or_super(), 1'b1));
    end else begin
      repeat ($urandom_range(1, 4)) push_item(rand_item());
    end
  endtask

  initial begin : stimulus
    int target;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    foreach (pool_gran[i]) pool_gran[i] = IndexBitsDef'($urandom);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_item(mk(REQ_LOAD, 64'd0, TAG_N, KIND_LOAD, PRIV_USER, 1'b1));
    push_item(mk(REQ_LOAD, '1, 8'hFF, KIND_NOP, PRIV_MACHINE, 1'b0));
    push_item(mk(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFF8, TAG_N, KIND_LOAD, PRIV_USER, 1'b1));
    push_item(mk(REQ_STORE, ADDR_X, TAG_C, KIND_LOAD, PRIV_USER, 1'b1));
    push_item(mk(REQ_STORE, ADDR_X, 8'hFF, KIND_LOAD, PRIV_MACHINE, 1'b1));
    push_item(mk(REQ_LOAD, ADDR_X, TAG_N, KIND_LOAD, PRIV_USER, 1'b1));
    push_item(mk(REQ_STORE, ADDR_Y, TAG_UT, KIND_LOAD, PRIV_USER, 1'b0));
    push_item(mk(REQ_CHECK, ADDR_X, TAG_N, KIND_NOP, PRIV_USER, 1'b0));
    push_item(mk(REQ_CHECK, ADDR_X, TAG_N, KIND_STORE, PRIV_MACHINE, 1'b1));
    push_item(mk(REQ_CHECK, ADDR_Y, TAG_N, KIND_LOAD, PRIV_USER, 1'b1));
    push_item(mk(REQ_CHECK, ADDR_Y, TAG_N, KIND_NOP, PRIV_SUPER, 1'b1));
    push_item(mk(REQ_STORE, ADDR_Z, TAG_C, KIND_LOAD, PRIV_MACHINE, 1'b1));
    push_item(mk(REQ_CHECK, ADDR_Z | 64'hFFFF_0000_0000_0000, TAG_N, KIND_FETCH,
                 PRIV_USER, 1'b1));
    push_item(mk(REQ_CHECK, ADDR_X, TAG_N, KIND_LOAD, PRIV_RSVD, 1'b1));
    push_item(mk(REQ_CHECK, ADDR_X, TAG_N, KIND_STORE, PRIV_RSVD, 1'b1));
    push_item(mk(REQ_STORE, ADDR_X, TAG_N, KIND_LOAD, PRIV_USER, 1'b1));
    push_item(mk(REQ_STORE, ADDR_Y, 8'd3, KIND_LOAD, PRIV_USER, 1'b1));
    push_item(mk(REQ_STORE, ADDR_X, TAG_C, KIND_LOAD, PRIV_SUPER, 1'b1));
    push_item(mk(REQ_CHECK, ADDR_X, TAG_N, KIND_STORE, PRIV_SUPER, 1'b1));
    push_item(mk(REQ_NOP, rand_addr(1'b0), 8'hFF, KIND_FETCH, PRIV_SUPER, 1'b1));
    push_item(mk(REQ_CHECK, 64'd0, TAG_N, KIND_FETCH, PRIV_SUPER, 1'b1));
    push_item(mk(REQ_CHECK, ADDR_X, TAG_N, KIND_FETCH, PRIV_SUPER, 1'b1));
    push_item(mk(REQ_CHECK, ADDR_Z, TAG_N, KIND_FETCH, PRIV_USER, 1'b1));
    push_item(mk(REQ_CHECK, 64'd8, TAG_N, KIND_FETCH, PRIV_USER, 1'b1));
    push_item(mk(REQ_LOAD, {32'($urandom), ADDR_Y[31:0]}, TAG_N, KIND_LOAD,
                 PRIV_USER, 1'b1));

    for (int phase = 0; phase < 4; phase++) begin
      write_narrow(!phase[0]);
      target = n_items + PHASE_ITEMS;
      while (n_items < target) run_sequence();
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);

    $display("covered %0d tag stores, %0d tag loads, %0d access checks, %0d no-op beats",
             n_store, n_load, n_check, n_nop);
    $display("across %0d address-width writes, with %0d store traps and %0d domain switches",
             n_cfg, trap_count, switch_count);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
